@@ rtl/chunk_rms_envelope_peak_meter_core_defines.svh @@
// Assertion macros shared by the meter RTL.
`ifndef CHUNK_RMS_ENVELOPE_PEAK_METER_CORE_DEFINES_SVH
`define CHUNK_RMS_ENVELOPE_PEAK_METER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define CRM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CRM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/crm_pkg.sv @@
`timescale 1ns / 1ps
package crm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int LEVEL_W     = 16;
  localparam int MAG_W       = 17;
  localparam int SQ_W        = 31;
  localparam int ACC_W       = 42;
  localparam int MEAN_W      = 31;
  localparam int RAD_W       = 32;
  localparam int ROOT_W      = 16;
  localparam int REM_W       = ROOT_W + 3;
  localparam int ROOT_STEP_W = $clog2(ROOT_W + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_WINDOW_DEPTH      = 128;
  localparam int DEF_MAX_CHUNK_SAMPLES = 4096;

  typedef struct packed {
    logic             clear;
    logic             emit;
    logic [ACC_W-1:0] acc;
  } crm_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_WRITE,
    ST_ROOT,
    ST_OUT
  } crm_state_e;

endpackage

@@ rtl/crm_if.sv @@
`timescale 1ns / 1ps
interface crm_in_if import crm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       chunk_end;
  logic                       file_start;

  modport source (output valid, sample, chunk_end, file_start, input ready);
  modport sink (input valid, sample, chunk_end, file_start, output ready);
endinterface

interface crm_out_if import crm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] envelope_level;
  logic [LEVEL_W-1:0] peak_level;

  modport source (output valid, envelope_level, peak_level, input ready);
  modport sink (input valid, envelope_level, peak_level, output ready);
endinterface

@@ rtl/chunk_rms_envelope_peak_meter_core.sv @@
`timescale 1ns / 1ps
// Moving-window RMS meter with peak hold. The front end squares each sample
// item, then does a saturating accumulate, and takes no new item until that
// one is accumulated, which waits while it needs a job and the queue is full.
// An item with chunk_end or file_start posts a job to a two-entry queue; for
// each chunk end the back end runs a 42-step restoring division for the chunk
// mean, the window update with the window mean taken as a shift, a 16-step
// square root, and output. Chunks shorter than 31 samples stall the input
// once the queue fills. WINDOW_DEPTH must be a power of two. A wrap flag
// marks whether the window ring has been filled once, so reset and file_start
// clear the window at once with no clearing pass. The result register holds
// a finished item while the next samples keep arriving.
module chunk_rms_envelope_peak_meter_core import crm_pkg::*; #(
  parameter int WINDOW_DEPTH      = DEF_WINDOW_DEPTH,
  parameter int MAX_CHUNK_SAMPLES = DEF_MAX_CHUNK_SAMPLES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crm_in_if.sink    in_i,
  crm_out_if.source out_o
);

  localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int POS_W = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = MEAN_W + $clog2(WINDOW_DEPTH);
  localparam int DVS_W = CNT_W;
  localparam int DVD_W = ACC_W;
  localparam int JOB_W = $bits(crm_job_t) + CNT_W;

  logic              push, full, pop, empty;
  crm_job_t          job_f, job_b;
  logic [CNT_W-1:0]  cnt_f, cnt_b;
  logic [JOB_W-1:0]  q_wdata, q_rdata;
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dividend, div_quot;
  logic [DVS_W-1:0]  div_divisor;
  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr, ram_raddr;
  logic [MEAN_W-1:0] ram_wdata, ram_rdata;

  crm_front #(
    .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES),
    .CNT_W             (CNT_W)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_f),
    .cnt_o  (cnt_f)
  );

  assign q_wdata        = {job_f, cnt_f};
  assign {job_b, cnt_b} = q_rdata;

  crm_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (empty)
  );

  crm_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  crm_ram #(
    .WIDTH (MEAN_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  crm_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CNT_W        (CNT_W),
    .POS_W        (POS_W),
    .SUM_W        (SUM_W),
    .DVD_W        (DVD_W),
    .DVS_W        (DVS_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_b),
    .cnt_i          (cnt_b),
    .empty_i        (empty),
    .pop_o          (pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .out_o          (out_o)
  );

endmodule

@@ rtl/crm_ram.sv @@
`timescale 1ns / 1ps
module crm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/crm_front.sv @@
`timescale 1ns / 1ps
`include "chunk_rms_envelope_peak_meter_core_defines.svh"
module crm_front import crm_pkg::*; #(
  parameter int MAX_CHUNK_SAMPLES = DEF_MAX_CHUNK_SAMPLES,
  parameter int CNT_W             = $clog2(MAX_CHUNK_SAMPLES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  crm_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output crm_job_t         job_o,
  output logic [CNT_W-1:0] cnt_o
);

  logic             busy_q, busy_d;
  logic [SQ_W-1:0]  sq_q;
  logic             end_q, start_q;
  logic [ACC_W-1:0] acc_q, acc_d, base_acc, new_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d, base_cnt, new_cnt;
  logic [ACC_W:0]   sum;
  logic [MAG_W-1:0] sx, mag;
  logic [2*MAG_W-1:0] prod;
  logic             accept, need_push, commit;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;

  assign sx   = {in_i.sample[SAMPLE_W-1], in_i.sample};
  assign mag  = sx[MAG_W-1] ? (~sx + MAG_W'(1)) : sx;
  assign prod = mag * mag;

  assign need_push = end_q || start_q;
  assign commit    = busy_q && (!need_push || !full_i);

  always_comb begin
    base_acc = start_q ? '0 : acc_q;
    base_cnt = start_q ? '0 : cnt_q;
    sum      = {1'b0, base_acc} + (ACC_W + 1)'(sq_q);
    new_acc  = base_acc;
    new_cnt  = base_cnt;
    if (base_cnt < CNT_W'(MAX_CHUNK_SAMPLES)) begin
      new_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
      new_cnt = base_cnt + 1'b1;
    end

    busy_d = busy_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (commit) begin
      busy_d = 1'b0;
      acc_d  = end_q ? '0 : new_acc;
      cnt_d  = end_q ? '0 : new_cnt;
    end
  end

  assign push_o = commit && need_push;
  assign job_o  = '{clear: start_q, emit: end_q, acc: new_acc};
  assign cnt_o  = new_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q    <= prod[SQ_W-1:0];
      end_q   <= in_i.chunk_end;
      start_q <= in_i.file_start;
    end
  end

  `CRM_ASSERT_IMPL(a_push_room, clk_i, rst_ni, push_o, !full_i, "push into a full queue")
  `CRM_ASSERT_IMPL(a_emit_count, clk_i, rst_ni, push_o && job_o.emit, cnt_o != '0, "chunk end with zero count")
  `CRM_ASSERT(a_count_cap, clk_i, rst_ni, cnt_q <= CNT_W'(MAX_CHUNK_SAMPLES), "chunk count above cap")

endmodule

@@ rtl/crm_queue.sv @@
`timescale 1ns / 1ps
module crm_queue import crm_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == FILL_W'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/crm_div.sv @@
`timescale 1ns / 1ps
module crm_div #(
  parameter int DVD_W = 42,
  parameter int DVS_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  quot_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVS_W:0]    shifted, diff;
  logic              ge;

  assign shifted = {rem_q, quot_q[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign done_o  = done_q;
  assign quot_o  = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quot_q <= {quot_q[DVD_W-2:0], ge};
    end
  end

endmodule

@@ rtl/crm_back.sv @@
`timescale 1ns / 1ps
`include "chunk_rms_envelope_peak_meter_core_defines.svh"
module crm_back import crm_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int CNT_W        = $clog2(DEF_MAX_CHUNK_SAMPLES + 1),
  parameter int POS_W        = $clog2(WINDOW_DEPTH),
  parameter int SUM_W        = MEAN_W + $clog2(WINDOW_DEPTH),
  parameter int DVD_W        = ACC_W,
  parameter int DVS_W        = CNT_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crm_job_t          job_i,
  input  logic [CNT_W-1:0]  cnt_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              div_start_o,
  output logic [DVD_W-1:0]  div_dividend_o,
  output logic [DVS_W-1:0]  div_divisor_o,
  input  logic              div_done_i,
  input  logic [DVD_W-1:0]  div_quot_i,
  output logic              ram_we_o,
  output logic [POS_W-1:0]  ram_waddr_o,
  output logic [MEAN_W-1:0] ram_wdata_o,
  output logic [POS_W-1:0]  ram_raddr_o,
  input  logic [MEAN_W-1:0] ram_rdata_i,
  crm_out_if.source         out_o
);

  localparam int LOG_DEPTH = $clog2(WINDOW_DEPTH);

  crm_state_e              state_q, state_d;
  logic                    wrapped_q, wrapped_d;
  logic [SUM_W-1:0]        sum_q, sum_d, sum_new;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [ROOT_W-1:0]       peak_q, peak_d;
  logic [MEAN_W-1:0]       mean_q, mean_d, old_val;
  logic [RAD_W-1:0]        rad_q, rad_d;
  logic [ROOT_W-1:0]       root_q, root_d;
  logic [REM_W-1:0]        rrem_q, rrem_d, rem_t, trial;
  logic [ROOT_STEP_W-1:0]  step_q, step_d;
  logic                    out_valid_q, out_valid_d, out_load;
  logic [LEVEL_W-1:0]      env_q, peak_out_q;

  assign old_val = wrapped_q ? ram_rdata_i : '0;
  assign sum_new = sum_q - SUM_W'(old_val) + SUM_W'(mean_q);
  assign rem_t   = {rrem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial   = REM_W'({root_q, 2'b01});

  assign ram_raddr_o = pos_q;
  assign ram_waddr_o = pos_q;
  assign ram_wdata_o = mean_q;

  always_comb begin
    state_d        = state_q;
    wrapped_d      = wrapped_q;
    sum_d          = sum_q;
    pos_d          = pos_q;
    peak_d         = peak_q;
    mean_d         = mean_q;
    rad_d          = rad_q;
    root_d         = root_q;
    rrem_d         = rrem_q;
    step_d         = step_q;
    pop_o          = 1'b0;
    div_start_o    = 1'b0;
    div_dividend_o = DVD_W'(job_i.acc);
    div_divisor_o  = DVS_W'(cnt_i);
    ram_we_o       = 1'b0;
    out_load       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (job_i.clear) begin
            wrapped_d = 1'b0;
            sum_d     = '0;
            pos_d     = '0;
            peak_d    = '0;
          end
          if (job_i.emit) begin
            div_start_o = 1'b1;
            state_d     = ST_MEAN;
          end
        end
      end
      ST_MEAN: begin
        if (div_done_i) begin
          mean_d  = div_quot_i[MEAN_W-1:0];
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we_o = 1'b1;
        sum_d    = sum_new;
        if (pos_q == POS_W'(WINDOW_DEPTH - 1)) begin
          pos_d     = '0;
          wrapped_d = 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
        rad_d   = RAD_W'(sum_new >> LOG_DEPTH);
        root_d  = '0;
        rrem_d  = '0;
        step_d  = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        rad_d  = {rad_q[RAD_W-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (rem_t >= trial) begin
          rrem_d = rem_t - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rrem_d = rem_t;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (step_q == ROOT_STEP_W'(ROOT_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          peak_d   = (root_q > peak_q) ? root_q : peak_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.envelope_level = env_q;
  assign out_o.peak_level     = peak_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wrapped_q   <= 1'b0;
      sum_q       <= '0;
      pos_q       <= '0;
      peak_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wrapped_q   <= wrapped_d;
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      peak_q      <= peak_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    rrem_q <= rrem_d;
    if (out_load) begin
      env_q      <= root_q;
      peak_out_q <= peak_d;
    end
  end

  `CRM_ASSERT_IMPL(a_div_done_state, clk_i, rst_ni, div_done_i, state_q == ST_MEAN, "divider result outside the wait state")
  `CRM_ASSERT_IMPL(a_peak_above_env, clk_i, rst_ni, out_valid_q, peak_out_q >= env_q, "peak below envelope")
  `CRM_ASSERT_NEXT(a_ring_wrap, clk_i, rst_ni, state_q == ST_WRITE && pos_q == POS_W'(WINDOW_DEPTH - 1), wrapped_q, "window ring wrap not marked")

endmodule
